// ===== design/midpoint_circle_rasterizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication
`define MCR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants and types of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int PIX_W    = 14;
  localparam int ADDR_W   = 32;
  localparam int COLOR_W  = 32;
  localparam int STRIDE_W = 16;
  localparam int BPP_W    = 3;
  localparam int FRAME_W  = 13;
  localparam int OUT_DW   = 96;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

  // Register reset values
  localparam logic [ADDR_W-1:0]   RST_BASE   = 32'd0;
  localparam logic [STRIDE_W-1:0] RST_STRIDE = 16'd3200;
  localparam logic [BPP_W-1:0]    RST_BPP    = 3'd4;
  localparam logic [FRAME_W-1:0]  RST_WIDTH  = 13'd800;
  localparam logic [FRAME_W-1:0]  RST_HEIGHT = 13'd800;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Decision term constants
  localparam int DEC_INIT     = 3;
  localparam int DEC_INC_KEEP = 6;
  localparam int DEC_INC_MOVE = 10;

  // Pixels per step
  localparam int PIX_PER_STEP = 8;

  // Step queue depth
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic [BPP_W-1:0]    bpp;
    logic [FRAME_W-1:0]  width;
    logic [FRAME_W-1:0]  height;
  } frame_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic active;
  } front_status_t;

endpackage

// ===== design/mcr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_fifo
// Short step queue between the circle front end and the pixel back end.
// ----------------------------------------------------------------------------
module mcr_fifo #(
  parameter int WIDTH = 81
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output mcr_pkg::q_status_t    status_o
);

  localparam int PTR_W = (mcr_pkg::QDEPTH > 1) ? $clog2(mcr_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(mcr_pkg::QDEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(mcr_pkg::QDEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mcr_pkg::QDEPTH - 1);

  logic [WIDTH-1:0] mem_q [mcr_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == DEPTH_C);
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== design/mcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_front
// Accepts start and step transactions, runs the midpoint decision term and
// queues one job of offsets per step.
// ----------------------------------------------------------------------------
module mcr_front #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [COORD_BITS-1:0]        cx_i,
  input  logic [COORD_BITS-1:0]        cy_i,
  input  logic [COORD_BITS-2:0]        radius_i,
  input  logic [mcr_pkg::COLOR_W-1:0]  color_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output logic [4*COORD_BITS+mcr_pkg::COLOR_W:0] entry_o,
  output mcr_pkg::front_status_t       status_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 4;
  localparam logic signed [DW-1:0] INIT_C = DW'(mcr_pkg::DEC_INIT);
  localparam logic signed [DW-1:0] KEEP_C = DW'(mcr_pkg::DEC_INC_KEEP);
  localparam logic signed [DW-1:0] MOVE_C = DW'(mcr_pkg::DEC_INC_MOVE);

  logic [C-1:0]                 off_x_q, off_x_d;
  logic [C-1:0]                 off_y_q, off_y_d;
  logic signed [DW-1:0]         dec_q, dec_d;
  logic [C-1:0]                 cx_q, cx_d;
  logic [C-1:0]                 cy_q, cy_d;
  logic [mcr_pkg::COLOR_W-1:0]  color_q, color_d;
  logic                         active_q, active_d;

  logic                 accept;
  logic signed [DW-1:0] a_ext, b_ext, r_ext;
  logic signed [DW-1:0] dec_step, x_next, y_next;
  logic                 done_step;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign a_ext = {{(DW-C){1'b0}}, off_x_q};
  assign b_ext = {{(DW-C){1'b0}}, off_y_q};
  assign r_ext = {{(DW-C+1){1'b0}}, radius_i};

  // Advance the decision term and offsets by one step
  always_comb begin
    x_next = a_ext + DW'(1);
    if (dec_q[DW-1] || dec_q == '0) begin
      dec_step = dec_q + (a_ext <<< 2) + KEEP_C;
      y_next   = b_ext;
    end else begin
      dec_step = dec_q + ((a_ext - b_ext) <<< 2) + MOVE_C;
      y_next   = b_ext - DW'(1);
    end
    done_step = (y_next < x_next);
  end

  // Update circle state on each accepted transaction
  always_comb begin
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    color_d  = color_q;
    active_d = active_q;
    if (accept) begin
      if (op_i == mcr_pkg::OP_START) begin
        off_x_d  = '0;
        off_y_d  = C'(radius_i);
        dec_d    = INIT_C - (r_ext <<< 1);
        cx_d     = cx_i;
        cy_d     = cy_i;
        color_d  = color_i;
        active_d = 1'b1;
      end else if (active_q) begin
        off_x_d  = x_next[C-1:0];
        off_y_d  = y_next[C-1:0];
        dec_d    = dec_step;
        active_d = !done_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= '0;
      off_y_q  <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else begin
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

  // Queue the pre-update offsets of each step
  assign push_o   = accept && (op_i == mcr_pkg::OP_STEP) && active_q;
  assign entry_o  = {done_step, color_q, off_y_q, off_x_q, cy_q, cx_q};
  assign status_o.active = active_q;

endmodule

// ===== design/mcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_back
// Expands each queued step into eight symmetric pixels, one per cycle unless
// stalled, and computes framebuffer addresses in a three-stage pipeline.
// ----------------------------------------------------------------------------
module mcr_back #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [4*COORD_BITS+mcr_pkg::COLOR_W:0] entry_i,
  input  logic                                  q_empty_i,
  output logic                                  pop_o,
  input  mcr_pkg::frame_cfg_t                   cfg_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mcr_pkg::PIX_W-1:0]             pixel_x_o,
  output logic [mcr_pkg::PIX_W-1:0]             pixel_y_o,
  output logic [mcr_pkg::ADDR_W-1:0]            pixel_address_o,
  output logic [mcr_pkg::COLOR_W-1:0]           pixel_color_o,
  output logic                                  outside_o,
  output logic                                  step_last_o,
  output logic                                  circle_done_o
);

  localparam int C     = COORD_BITS;
  localparam int EW    = 4*COORD_BITS + mcr_pkg::COLOR_W + 1;
  localparam int EXW   = COORD_BITS + 2;
  localparam int CMPW  = (EXW > mcr_pkg::FRAME_W) ? EXW : mcr_pkg::FRAME_W;
  localparam int PYW   = EXW + mcr_pkg::STRIDE_W;
  localparam int PXW   = EXW + mcr_pkg::BPP_W;
  localparam int IDX_W = $clog2(mcr_pkg::PIX_PER_STEP);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(mcr_pkg::PIX_PER_STEP - 1);
  localparam int AW    = mcr_pkg::ADDR_W;
  localparam int CLW   = mcr_pkg::COLOR_W;

  logic adv;

  // Sequencer stage
  logic             seq_vld_q, seq_vld_d;
  logic [EW-1:0]    seq_ent_q, seq_ent_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             seq_free;

  logic [C-1:0]         e_cx, e_cy, e_a, e_b;
  logic [CLW-1:0]       e_color;
  logic                 e_done;
  logic [C-1:0]         u_off, v_off;
  logic signed [EXW-1:0] cx_ext, cy_ext, u_ext, v_ext, px_c, py_c;

  // Stage 1: coordinates
  logic                  s1_vld_q;
  logic signed [EXW-1:0] s1_px_q, s1_py_q;
  logic                  s1_last_q, s1_done_q;
  logic [CLW-1:0]        s1_color_q;

  // Stage 2: bounds and products
  logic                  s2_vld_q;
  logic [mcr_pkg::PIX_W-1:0] s2_px_q, s2_py_q;
  logic                  s2_out_q;
  logic [AW-1:0]         s2_prod_y_q, s2_prod_x_q;
  logic                  s2_last_q, s2_done_q;
  logic [CLW-1:0]        s2_color_q;

  logic                  outside_c;
  logic [PYW-1:0]        prod_y_c;
  logic [PXW-1:0]        prod_x_c;

  // Output register
  logic                      out_vld_q;
  logic [mcr_pkg::PIX_W-1:0] out_px_q, out_py_q;
  logic [AW-1:0]             out_addr_q;
  logic [CLW-1:0]            out_color_q;
  logic                      out_out_q, out_last_q, out_done_q;

  // Move the whole pipeline when the output register frees up
  assign adv = !out_vld_q || out_ready_i;

  assign seq_free = !seq_vld_q || (idx_q == IDX_LAST);
  assign pop_o    = adv && seq_free && !q_empty_i;

  // Load a new step or walk through the octants
  always_comb begin
    seq_vld_d = seq_vld_q;
    seq_ent_d = seq_ent_q;
    idx_d     = idx_q;
    if (adv) begin
      if (seq_free) begin
        seq_vld_d = !q_empty_i;
        seq_ent_d = entry_i;
        idx_d     = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_vld_q <= 1'b0;
      idx_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      seq_vld_q <= seq_vld_d;
      idx_q     <= idx_d;
      if (adv) begin
        s1_vld_q  <= seq_vld_q;
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seq_ent_q <= seq_ent_d;
  end

  // Unpack the job and pick this pixel's octant
  assign {e_done, e_color, e_b, e_a, e_cy, e_cx} = seq_ent_q;

  assign u_off  = idx_q[2] ? e_b : e_a;
  assign v_off  = idx_q[2] ? e_a : e_b;
  assign cx_ext = {2'b00, e_cx};
  assign cy_ext = {2'b00, e_cy};
  assign u_ext  = {2'b00, u_off};
  assign v_ext  = {2'b00, v_off};
  assign px_c   = idx_q[0] ? (cx_ext - u_ext) : (cx_ext + u_ext);
  assign py_c   = idx_q[1] ? (cy_ext - v_ext) : (cy_ext + v_ext);

  // Bounds test and address products
  assign outside_c = s1_px_q[EXW-1] || s1_py_q[EXW-1]
                  || (CMPW'($unsigned(s1_px_q)) >= CMPW'(cfg_i.width))
                  || (CMPW'($unsigned(s1_py_q)) >= CMPW'(cfg_i.height));
  assign prod_y_c  = PYW'($unsigned(s1_py_q)) * PYW'(cfg_i.stride);
  assign prod_x_c  = PXW'($unsigned(s1_px_q)) * PXW'(cfg_i.bpp);

  // Data path registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q     <= px_c;
      s1_py_q     <= py_c;
      s1_last_q   <= (idx_q == IDX_LAST);
      s1_done_q   <= (idx_q == IDX_LAST) && e_done;
      s1_color_q  <= e_color;

      s2_px_q     <= mcr_pkg::PIX_W'(s1_px_q);
      s2_py_q     <= mcr_pkg::PIX_W'(s1_py_q);
      s2_out_q    <= outside_c;
      s2_prod_y_q <= AW'(prod_y_c);
      s2_prod_x_q <= AW'(prod_x_c);
      s2_last_q   <= s1_last_q;
      s2_done_q   <= s1_done_q;
      s2_color_q  <= s1_color_q;

      out_px_q    <= s2_px_q;
      out_py_q    <= s2_py_q;
      out_addr_q  <= s2_out_q ? '0 : (cfg_i.base + s2_prod_y_q + s2_prod_x_q);
      out_color_q <= s2_color_q;
      out_out_q   <= s2_out_q;
      out_last_q  <= s2_last_q;
      out_done_q  <= s2_done_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign pixel_x_o       = out_px_q;
  assign pixel_y_o       = out_py_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign outside_o       = out_out_q;
  assign step_last_o     = out_last_q;
  assign circle_done_o   = out_done_q;

endmodule

// ===== design/midpoint_circle_rasterizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_core
// Midpoint circle rasterizer emitting eight symmetric pixels per step with
// framebuffer byte addresses.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata: center_x, center_y,
//                                                   radius, color; tuser: operation
//   m_axis    out        m_axis_tvalid/tready       tdata: pixel_x, pixel_y,
//                                                   pixel_address, pixel_color;
//                                                   tlast: step_last;
//                                                   tuser: outside, circle_done
//   cfg       in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A start transaction yields no pixels. A step yields eight pixels, one per cycle
// while m_axis is not stalled; the next step is taken as the last pixel issues.
// A step passes the step queue, sequencer, stage 1, stage 2 and output register.
// A two-entry step queue lets the input side run ahead while pixels stall.
// Reset clears control state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "midpoint_circle_rasterizer_core_macros.svh"

module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // center_x, center_y, radius, color, zero pad
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((3*COORD_BITS+31+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic [0:0]                       s_axis_tuser,
  // pixel_x, pixel_y, pixel_address, pixel_color, zero pad
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mcr_pkg::OUT_DW-1:0]       m_axis_tdata,
  output logic                             m_axis_tlast,
  // outside, circle_done
  output logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int C     = COORD_BITS;
  localparam int EW    = 4*COORD_BITS + mcr_pkg::COLOR_W + 1;
  localparam int PADW  = mcr_pkg::OUT_DW - 2*mcr_pkg::PIX_W - mcr_pkg::ADDR_W
                         - mcr_pkg::COLOR_W;

  mcr_pkg::frame_cfg_t   cfg_q, cfg_d;
  mcr_pkg::q_status_t    q_stat;
  mcr_pkg::front_status_t front_stat;

  logic          q_push, q_pop;
  logic [EW-1:0] q_wdata, q_rdata;

  logic [mcr_pkg::PIX_W-1:0]   pix_x, pix_y;
  logic [mcr_pkg::ADDR_W-1:0]  pix_addr;
  logic [mcr_pkg::COLOR_W-1:0] pix_color;
  logic                        pix_out, pix_done;
  logic                        start_acc;

  // Write configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcr_pkg::CFG_BASE:   cfg_d.base   = cfg_data_i[mcr_pkg::ADDR_W-1:0];
        mcr_pkg::CFG_STRIDE: cfg_d.stride = cfg_data_i[mcr_pkg::STRIDE_W-1:0];
        mcr_pkg::CFG_BPP:    cfg_d.bpp    = cfg_data_i[mcr_pkg::BPP_W-1:0];
        mcr_pkg::CFG_WIDTH:  cfg_d.width  = cfg_data_i[mcr_pkg::FRAME_W-1:0];
        mcr_pkg::CFG_HEIGHT: cfg_d.height = cfg_data_i[mcr_pkg::FRAME_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base   <= mcr_pkg::RST_BASE;
      cfg_q.stride <= mcr_pkg::RST_STRIDE;
      cfg_q.bpp    <= mcr_pkg::RST_BPP;
      cfg_q.width  <= mcr_pkg::RST_WIDTH;
      cfg_q.height <= mcr_pkg::RST_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mcr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser[0]),
    .cx_i       (s_axis_tdata[C-1:0]),
    .cy_i       (s_axis_tdata[2*C-1:C]),
    .radius_i   (s_axis_tdata[3*C-2:2*C]),
    .color_i    (s_axis_tdata[3*C+mcr_pkg::COLOR_W-2:3*C-1]),
    .q_full_i   (q_stat.full),
    .push_o     (q_push),
    .entry_o    (q_wdata),
    .status_o   (front_stat)
  );

  mcr_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_stat)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (q_rdata),
    .q_empty_i       (q_stat.empty),
    .pop_o           (q_pop),
    .cfg_i           (cfg_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .pixel_x_o       (pix_x),
    .pixel_y_o       (pix_y),
    .pixel_address_o (pix_addr),
    .pixel_color_o   (pix_color),
    .outside_o       (pix_out),
    .step_last_o     (m_axis_tlast),
    .circle_done_o   (pix_done)
  );

  // Pack the pixel transaction
  assign m_axis_tdata = {{PADW{1'b0}}, pix_color, pix_addr, pix_y, pix_x};
  assign m_axis_tuser = {pix_done, pix_out};

  // Flag an accepted start transaction
  assign start_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == mcr_pkg::OP_START);

  // Checks
  `MCR_ASSERT(a_push_room, q_push, !q_stat.full, "step queued while queue full")
  `MCR_ASSERT(a_pop_data, q_pop, !q_stat.empty, "step popped from empty queue")
  `MCR_ASSERT_NEXT(a_start_arms, start_acc, front_stat.active, "start did not arm circle")
  `MCR_ASSERT(a_done_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "done without tlast")

endmodule
